[rtl/rob_pkg.sv]
// Package for the reorder buffer unit: sizes, action and status codes,
// request and response structs. No dependencies.
package rob_pkg;

  localparam int RobDepth  = 64;
  localparam int PtrW      = $clog2(RobDepth);
  localparam int CntW      = $clog2(RobDepth + 1);
  localparam int PregW     = 8;
  localparam int PayloadW  = 64;
  localparam int EntryW    = PayloadW + 4 * PregW + 1;
  localparam int ActionW   = 3;
  localparam int StatusW   = 3;
  localparam int SlotW     = 6;
  localparam int InTdataW  = 104;
  localparam int OutTdataW = 112;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_MARK_EXEC = 3'd1,
    ACT_MARK_DISP = 3'd2,
    ACT_COMMIT    = 3'd3,
    ACT_DEQUEUE   = 3'd4,
    ACT_POP       = 3'd5
  } rob_action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOT_EXEC = 3'd3,
    ST_IGNORED  = 3'd4
  } rob_status_e;

  typedef struct packed {
    rob_action_e         action;
    logic [PayloadW-1:0] instr_word;
    logic [PregW-1:0]    new_dest_reg;
    logic [PregW-1:0]    old_dest_reg;
    logic [PregW-1:0]    src_reg_a;
    logic [PregW-1:0]    src_reg_b;
    logic                float_op;
    logic [SlotW-1:0]    slot;
  } rob_req_t;

  typedef struct packed {
    rob_status_e         status;
    logic [SlotW-1:0]    slot_index;
    logic [PayloadW-1:0] out_instr_word;
    logic [PregW-1:0]    out_new_dest;
    logic [PregW-1:0]    out_old_dest;
    logic [PregW-1:0]    out_src_a;
    logic [PregW-1:0]    out_src_b;
    logic                out_float;
    logic                out_dispatched;
    logic                out_executed;
  } rob_rsp_t;

endpackage

[rtl/rob_ram.sv]
// Generic single-write, single-read RAM with registered, write-first read.
// No dependencies.
module rob_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rob_ctrl.sv]
// Reorder buffer state: head, tail, occupancy, slot flags and the entry RAM.
// Depends on rob_pkg and rob_ram.
module rob_ctrl import rob_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            req_fire_i,
  input  rob_req_t        req_i,
  output rob_rsp_t        rsp_o
);

  logic [PtrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     occ_q, occ_d, size_q, size_d;
  logic [RobDepth-1:0] valid_q, valid_d, disp_q, disp_d, exec_q, exec_d;
  logic [CntW-1:0]     head_inc, tail_inc;
  logic [PtrW-1:0]     head_nxt, tail_nxt;
  logic                we;
  logic [EntryW-1:0]   wdata, rdata;
  logic                slot_ok;

  rob_ram #(
    .Width (EntryW),
    .Depth (RobDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (wdata),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  assign head_inc = {1'b0, head_q} + CntW'(1);
  assign tail_inc = {1'b0, tail_q} + CntW'(1);
  assign head_nxt = (head_inc >= size_q) ? '0 : head_inc[PtrW-1:0];
  assign tail_nxt = (tail_inc >= size_q) ? '0 : tail_inc[PtrW-1:0];
  assign wdata    = {req_i.float_op, req_i.src_reg_b, req_i.src_reg_a,
                     req_i.old_dest_reg, req_i.new_dest_reg, req_i.instr_word};
  assign slot_ok  = ({1'b0, req_i.slot} < size_q) && valid_q[req_i.slot];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    occ_d   = occ_q;
    size_d  = size_q;
    valid_d = valid_q;
    disp_d  = disp_q;
    exec_d  = exec_q;
    we      = 1'b0;
    rsp_o   = '0;
    if (cfg_we_i) begin
      if ((cfg_wdata_i == '0) || (cfg_wdata_i > CntW'(RobDepth))) begin
        size_d = CntW'(RobDepth);
      end else begin
        size_d = cfg_wdata_i;
      end
      head_d  = '0;
      tail_d  = '0;
      occ_d   = '0;
      valid_d = '0;
      disp_d  = '0;
      exec_d  = '0;
    end else if (req_fire_i) begin
      case (req_i.action)
        ACT_INSERT: begin
          if (occ_q >= size_q) begin
            rsp_o.status = ST_FULL;
          end else begin
            we              = 1'b1;
            valid_d[tail_q] = 1'b1;
            disp_d[tail_q]  = 1'b0;
            exec_d[tail_q]  = 1'b0;
            rsp_o.slot_index = tail_q;
            occ_d  = occ_q + CntW'(1);
            tail_d = tail_nxt;
          end
        end
        ACT_MARK_EXEC, ACT_MARK_DISP: begin
          if (!slot_ok) begin
            rsp_o.status = ST_IGNORED;
          end else if (req_i.action == ACT_MARK_EXEC) begin
            exec_d[req_i.slot] = 1'b1;
          end else begin
            disp_d[req_i.slot] = 1'b1;
          end
        end
        ACT_COMMIT, ACT_DEQUEUE, ACT_POP: begin
          if (occ_q == '0) begin
            rsp_o.status = ST_EMPTY;
          end else if ((req_i.action == ACT_COMMIT) && !exec_q[head_q]) begin
            rsp_o.status = ST_NOT_EXEC;
          end else begin
            if (req_i.action != ACT_POP) begin
              {rsp_o.out_float, rsp_o.out_src_b, rsp_o.out_src_a,
               rsp_o.out_old_dest, rsp_o.out_new_dest,
               rsp_o.out_instr_word} = rdata;
              rsp_o.out_dispatched = disp_q[head_q];
              rsp_o.out_executed   = exec_q[head_q];
            end
            rsp_o.slot_index = head_q;
            valid_d[head_q]  = 1'b0;
            occ_d  = occ_q - CntW'(1);
            head_d = head_nxt;
          end
        end
        default: begin
          rsp_o.status = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      size_q  <= CntW'(RobDepth);
      valid_q <= '0;
      disp_q  <= '0;
      exec_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      size_q  <= size_d;
      valid_q <= valid_d;
      disp_q  <= disp_d;
      exec_q  <= exec_d;
    end
  end

`ifndef SYNTHESIS
  a_occ_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= size_q) else $error("occupancy above size");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (head_q == tail_q)) else $error("empty with head != tail");
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q)) else $error("valid flags disagree with occupancy");
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, head_q} < size_q) && ({1'b0, tail_q} < size_q))
    else $error("pointer beyond wrap point");
  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire_i && !cfg_we_i && (req_i.action == ACT_INSERT) && (occ_q < size_q))
    |=> valid_q[$past(tail_q)]) else $error("inserted slot not valid");
`endif

endmodule

[rtl/reorder_buffer_unit.sv]
// Top level of the reorder buffer unit: input and result registers around
// the buffer control. Depends on rob_pkg and rob_ctrl.
//
// Usage:
//   Slave channel s_axis carries one operation per word: tuser holds the
//   action, tdata the insert payload and the slot for mark operations.
//   Master channel m_axis returns exactly one result word per operation:
//   tuser holds the status, tdata the slot index and the removed head fields.
//   cfg_we_i/cfg_wdata_i set the number of slots in use and empty the buffer;
//   write it only while no operation is in flight.
// Path: input word to the input register, its result to the result register.
// Throughput: one operation per cycle unless m_axis stalls; each action is one
//   slot access, the head entry held in a registered RAM read so it is ready.
// Reset: head, tail, occupancy and all slot flags clear; 64 slots in use.
// Stall: when m_axis_tready is low the result register holds and the input
//   register takes one more word, then s_axis_tready drops until the
//   receiver drains.
module reorder_buffer_unit import rob_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CntW-1:0]      cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // instr_word[63:0], new_dest_reg[71:64], old_dest_reg[79:72],
  // src_reg_a[87:80], src_reg_b[95:88], float_op[96], slot[102:97], pad[103]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // action[2:0]
  input  logic [ActionW-1:0]   s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // slot_index[5:0], out_instr_word[69:6], out_new_dest[77:70],
  // out_old_dest[85:78], out_src_a[93:86], out_src_b[101:94], out_float[102],
  // out_dispatched[103], out_executed[104], pad[111:105]
  output logic [OutTdataW-1:0] m_axis_tdata,
  // status[2:0]
  output logic [StatusW-1:0]   m_axis_tuser
);

  rob_req_t req_q, req_d;
  rob_rsp_t rsp_q, rsp;
  logic     in_vld_q, out_vld_q;
  logic     advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    req_d.action       = rob_action_e'(s_axis_tuser);
    req_d.instr_word   = s_axis_tdata[63:0];
    req_d.new_dest_reg = s_axis_tdata[71:64];
    req_d.old_dest_reg = s_axis_tdata[79:72];
    req_d.src_reg_a    = s_axis_tdata[87:80];
    req_d.src_reg_b    = s_axis_tdata[95:88];
    req_d.float_op     = s_axis_tdata[96];
    req_d.slot         = s_axis_tdata[102:97];
  end

  rob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_fire_i  (advance),
    .req_i       (req_q),
    .rsp_o       (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= req_d;
    end
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = rsp_q.status;
  assign m_axis_tdata  = {7'b0, rsp_q.out_executed, rsp_q.out_dispatched,
                          rsp_q.out_float, rsp_q.out_src_b, rsp_q.out_src_a,
                          rsp_q.out_old_dest, rsp_q.out_new_dest,
                          rsp_q.out_instr_word, rsp_q.slot_index};

endmodule
